@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands, included by the top-level sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked at every rising clock edge outside of reset.
`define ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

@@ rtl/mast_pkg.sv @@
// ----------------------------------------------------------------------------
// mast_pkg
// Shared widths, codes, reset values and types of the step target sequencer.
// ----------------------------------------------------------------------------
package mast_pkg;

    localparam int AXES_DEFAULT       = 5;
    localparam int VALUE_BITS_DEFAULT = 16;

    localparam int OP_W        = 2;
    localparam int AXIS_W      = 3;
    localparam int MASK_W      = 5;
    localparam int TARGET_W    = 16;
    localparam int LIMIT_W     = 16;
    localparam int STEP_W      = 8;
    localparam int REF_W       = 3;
    localparam int FRAME_W     = 2;
    localparam int OUT_AXES    = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OP_W-1:0] OP_ENCODER = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP    = 2'd1;
    localparam logic [OP_W-1:0] OP_LEFT    = 2'd2;
    localparam logic [OP_W-1:0] OP_RIGHT   = 2'd3;

    localparam logic [FRAME_W-1:0] FRAME_NONE   = 2'd0;
    localparam logic [FRAME_W-1:0] FRAME_PAUSE  = 2'd1;
    localparam logic [FRAME_W-1:0] FRAME_TARGET = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_TRAVEL_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENCODER_STEP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_AXIS = 2'd2;

    localparam logic signed [LIMIT_W-1:0] TRAVEL_LIMIT_RESET   = 16'sd7000;
    localparam logic [STEP_W-1:0]         ENCODER_STEP_RESET   = 8'd50;
    localparam logic [REF_W-1:0]          REFERENCE_AXIS_RESET = 3'd2;

    // Decision of the sequencer control for one item, shared by all axes.
    typedef struct packed {
        logic                move_left;
        logic                move_right;
        logic                swap;
        logic [FRAME_W-1:0]  frame_kind;
        logic                blocked;
    } mast_ctrl_t;

    // Per-axis command for one item.
    typedef struct packed {
        logic enc_hit;
        logic clk_level;
        logic dt_level;
        logic move_left;
        logic move_right;
        logic swap;
    } mast_lane_cmd_t;

endpackage

@@ rtl/mast_lane.sv @@
// ----------------------------------------------------------------------------
// mast_lane
// State of one axis: target, previous target, step distance and encoder CLK.
// ----------------------------------------------------------------------------
module mast_lane
    import mast_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mast_lane_cmd_t        cmd,
    input  logic [STEP_W-1:0]     encoder_step,
    output logic [VALUE_BITS-1:0] target,
    output logic [VALUE_BITS-1:0] target_next,
    output logic [VALUE_BITS-1:0] distance
);

    logic [VALUE_BITS-1:0] target_reg;
    logic [VALUE_BITS-1:0] prev_reg;
    logic [VALUE_BITS-1:0] prev_next;
    logic [VALUE_BITS-1:0] dist_reg;
    logic [VALUE_BITS-1:0] dist_next;
    logic                  last_clk_reg;
    logic                  last_clk_next;
    logic [VALUE_BITS-1:0] step_ext;

    assign step_ext = VALUE_BITS'(encoder_step);

    always_comb
    begin
        dist_next     = dist_reg;
        last_clk_next = last_clk_reg;
        target_next   = target_reg;
        prev_next     = prev_reg;

        if (cmd.enc_hit)
        begin
            if (cmd.clk_level && !last_clk_reg)
            begin
                dist_next = cmd.dt_level ? (dist_reg - step_ext) : (dist_reg + step_ext);
            end
            last_clk_next = cmd.clk_level;
        end

        if (cmd.swap)
        begin
            target_next = prev_reg;
            prev_next   = target_reg;
        end
        else if (cmd.move_left)
        begin
            prev_next = target_reg;
            // A distance larger than the target clamps the target to zero.
            if ($signed(dist_reg) > $signed(target_reg))
            begin
                target_next = '0;
            end
            else
            begin
                target_next = target_reg - dist_reg;
            end
        end
        else if (cmd.move_right)
        begin
            prev_next   = target_reg;
            target_next = target_reg + dist_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            prev_reg     <= '0;
            dist_reg     <= '0;
            last_clk_reg <= 1'b0;
        end
        else
        begin
            target_reg   <= target_next;
            prev_reg     <= prev_next;
            dist_reg     <= dist_next;
            last_clk_reg <= last_clk_next;
        end
    end

    assign target   = target_reg;
    assign distance = dist_reg;

endmodule

@@ rtl/mast_ctrl.sv @@
// ----------------------------------------------------------------------------
// mast_ctrl
// Pause and direction tracking, travel limit check and frame selection.
// ----------------------------------------------------------------------------
module mast_ctrl
    import mast_pkg::*;
#(
    parameter int AXES       = AXES_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  logic [OP_W-1:0]                     op,
    input  logic signed [LIMIT_W-1:0]           travel_limit,
    input  logic [REF_W-1:0]                    reference_axis,
    input  logic [AXES-1:0][VALUE_BITS-1:0]     lane_target,
    input  logic [AXES-1:0][VALUE_BITS-1:0]     lane_distance,
    output mast_ctrl_t                          ctrl
);

    localparam int IDX_W = REF_W + 1;
    localparam int CMP_W = (VALUE_BITS > LIMIT_W) ? VALUE_BITS : LIMIT_W;

    logic                  paused_reg;
    logic                  paused_next;
    logic                  last_dir_reg;
    logic                  last_dir_next;
    logic                  dir;
    logic [IDX_W-1:0]      ref_idx;
    logic [VALUE_BITS-1:0] ref_target;
    logic [VALUE_BITS-1:0] ref_distance;
    logic [VALUE_BITS-1:0] ref_sum;
    logic                  below_limit;

    // A reference axis beyond the last axis saturates to the last one.
    always_comb
    begin
        ref_idx = ({1'b0, reference_axis} < IDX_W'(AXES)) ? {1'b0, reference_axis}
                                                          : IDX_W'(AXES - 1);
        ref_target   = '0;
        ref_distance = '0;
        for (int i = 0; i < AXES; i++)
        begin
            if (ref_idx == IDX_W'(i))
            begin
                ref_target   = lane_target[i];
                ref_distance = lane_distance[i];
            end
        end
    end

    assign ref_sum     = ref_target + ref_distance;
    assign below_limit = $signed(CMP_W'(travel_limit)) > $signed(CMP_W'($signed(ref_sum)));
    assign dir         = (op == OP_RIGHT);

    always_comb
    begin
        ctrl          = '0;
        paused_next   = paused_reg;
        last_dir_next = last_dir_reg;

        if (fire)
        begin
            case (op)
                OP_ENCODER:
                begin
                    ctrl.frame_kind = FRAME_NONE;
                end
                OP_STOP:
                begin
                    paused_next     = 1'b1;
                    ctrl.frame_kind = FRAME_PAUSE;
                end
                OP_LEFT, OP_RIGHT:
                begin
                    if (paused_reg)
                    begin
                        // Resume: no motion, only a swap on a direction change.
                        paused_next     = 1'b0;
                        ctrl.swap       = (last_dir_reg != dir);
                        last_dir_next   = dir;
                        ctrl.frame_kind = FRAME_TARGET;
                    end
                    else if (!dir)
                    begin
                        ctrl.move_left  = 1'b1;
                        last_dir_next   = 1'b0;
                        ctrl.frame_kind = FRAME_TARGET;
                    end
                    else if (below_limit)
                    begin
                        ctrl.move_right = 1'b1;
                        last_dir_next   = 1'b1;
                        ctrl.frame_kind = FRAME_TARGET;
                    end
                    else
                    begin
                        ctrl.blocked = 1'b1;
                    end
                end
                default:
                begin
                    ctrl.frame_kind = FRAME_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg   <= 1'b0;
            last_dir_reg <= 1'b0;
        end
        else
        begin
            paused_reg   <= paused_next;
            last_dir_reg <= last_dir_next;
        end
    end

endmodule

@@ rtl/multi_axis_step_target_sequencer.sv @@
// ----------------------------------------------------------------------------
// multi_axis_step_target_sequencer
// Five-axis step target sequencer with encoder distance control, limit check
// and pause/resume handling.
//
// The block takes one item per clock cycle while the result side does not
// stall. The accepted item sits in the input register while the axis lanes
// and the control compute the new state and the result; both load together
// as the item leaves the input register, so the next item sees the new
// state without any wait. Stall on the result side holds the result
// register; the input register still takes one more item while a result waits.
// Configuration must be written while no item is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_axis_step_target_sequencer
    import mast_pkg::*;
#(
    parameter int AXES       = AXES_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [OP_W-1:0]               op,
    input  logic [AXIS_W-1:0]             axis,
    input  logic                          clk_level,
    input  logic                          dt_level,
    input  logic [MASK_W-1:0]             enable_mask,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [FRAME_W-1:0]            frame_kind,
    output logic                          limit_blocked,
    output logic signed [TARGET_W-1:0]    target_axis0,
    output logic signed [TARGET_W-1:0]    target_axis1,
    output logic signed [TARGET_W-1:0]    target_axis2,
    output logic signed [TARGET_W-1:0]    target_axis3,
    output logic signed [TARGET_W-1:0]    target_axis4
);

    // Configuration registers.
    logic signed [LIMIT_W-1:0] travel_limit_reg;
    logic [STEP_W-1:0]         encoder_step_reg;
    logic [REF_W-1:0]          reference_axis_reg;

    // Input register.
    logic                  in_full_reg;
    logic [OP_W-1:0]       op_reg;
    logic [AXIS_W-1:0]     axis_reg;
    logic                  clk_level_reg;
    logic                  dt_level_reg;
    logic [MASK_W-1:0]     mask_reg;

    // Result register.
    logic                  out_valid_reg;
    logic [FRAME_W-1:0]    frame_kind_reg;
    logic                  blocked_reg;
    logic [OUT_AXES-1:0][TARGET_W-1:0] targets_reg;
    logic [OUT_AXES-1:0][TARGET_W-1:0] targets_next;

    logic                  advance;
    logic                  fire;
    logic                  in_accept;
    mast_ctrl_t            ctrl;

    logic [AXES-1:0][VALUE_BITS-1:0] lane_target;
    logic [AXES-1:0][VALUE_BITS-1:0] lane_target_next;
    logic [AXES-1:0][VALUE_BITS-1:0] lane_distance;
    mast_lane_cmd_t [AXES-1:0]       lane_cmd;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_full_reg && advance;
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_limit_reg   <= TRAVEL_LIMIT_RESET;
            encoder_step_reg   <= ENCODER_STEP_RESET;
            reference_axis_reg <= REFERENCE_AXIS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TRAVEL_LIMIT:   travel_limit_reg   <= $signed(cfg_data[LIMIT_W-1:0]);
                REG_ENCODER_STEP:   encoder_step_reg   <= cfg_data[STEP_W-1:0];
                REG_REFERENCE_AXIS: reference_axis_reg <= cfg_data[REF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg        <= op;
            axis_reg      <= axis;
            clk_level_reg <= clk_level;
            dt_level_reg  <= dt_level;
            mask_reg      <= enable_mask;
        end
    end

    mast_ctrl #(
        .AXES       (AXES),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .op             (op_reg),
        .travel_limit   (travel_limit_reg),
        .reference_axis (reference_axis_reg),
        .lane_target    (lane_target),
        .lane_distance  (lane_distance),
        .ctrl           (ctrl)
    );

    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        logic enabled;

        // Enable bits exist only for the axes covered by the mask.
        if (i < MASK_W)
        begin : g_en
            assign enabled = mask_reg[i];
        end
        else
        begin : g_no_en
            assign enabled = 1'b0;
        end

        always_comb
        begin
            lane_cmd[i].enc_hit    = fire && (op_reg == OP_ENCODER)
                                     && (axis_reg == AXIS_W'(i));
            lane_cmd[i].clk_level  = clk_level_reg;
            lane_cmd[i].dt_level   = dt_level_reg;
            lane_cmd[i].move_left  = ctrl.move_left && enabled;
            lane_cmd[i].move_right = ctrl.move_right && enabled;
            lane_cmd[i].swap       = ctrl.swap && enabled;
        end

        mast_lane #(
            .VALUE_BITS (VALUE_BITS)
        ) u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (lane_cmd[i]),
            .encoder_step (encoder_step_reg),
            .target       (lane_target[i]),
            .target_next  (lane_target_next[i]),
            .distance     (lane_distance[i])
        );
    end

    for (genvar k = 0; k < OUT_AXES; k++)
    begin : g_out
        if (k < AXES)
        begin : g_shown
            assign targets_next[k] = TARGET_W'(lane_target_next[k]);
        end
        else
        begin : g_absent
            assign targets_next[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_full_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            frame_kind_reg <= ctrl.frame_kind;
            blocked_reg    <= ctrl.blocked;
            targets_reg    <= targets_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_kind    = frame_kind_reg;
    assign limit_blocked = blocked_reg;
    assign target_axis0  = $signed(targets_reg[0]);
    assign target_axis1  = $signed(targets_reg[1]);
    assign target_axis2  = $signed(targets_reg[2]);
    assign target_axis3  = $signed(targets_reg[3]);
    assign target_axis4  = $signed(targets_reg[4]);

    `ASSERT_CLK(a_fire_gives_result, fire |=> out_valid_reg, "item lost")
    `ASSERT_CLK(a_stop_pause, fire && op_reg == OP_STOP |=> frame_kind_reg == FRAME_PAUSE, "no pause")
    `ASSERT_IMPLY(a_blk_none, out_valid_reg && blocked_reg, frame_kind_reg == FRAME_NONE, "blocked")
    `ASSERT_IMPLY(a_stall_needs_item, in_stall, in_full_reg && out_valid_reg, "stall while empty")

endmodule
